[src/sam_pkg.sv]
// Shared types and constants for the sparse array map.
package sam_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 3;
    localparam int SHIFT_W      = 5;
    localparam int LIVE_W       = 7;

    typedef enum logic [CMD_W-1:0] {
        OP_READ    = 3'd0,
        OP_ASSIGN  = 3'd1,
        OP_ADD     = 3'd2,
        OP_PREINC  = 3'd3,
        OP_POSTINC = 3'd4,
        OP_SHL     = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch request, restart scan
        logic clear;  // wipe one tag entry per cycle
        logic scan;   // read one entry per cycle
        logic exec;   // read-modify-write and result
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic idx_last;
    } t_ctrl_sts;

endpackage

[src/sam_ctrl.sv]
// Controller state machine for the sparse array map.
module sam_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sam_pkg::t_ctrl_sts    i_sts,
    output sam_pkg::t_ctrl_cmd    o_cmd
);

    sam_pkg::t_state r_state;
    sam_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sam_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            sam_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = sam_pkg::ST_IDLE;
                end
            end
            sam_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = sam_pkg::ST_SCAN;
                end
            end
            sam_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = sam_pkg::ST_LAST;
                end
            end
            sam_pkg::ST_LAST: begin
                n_state = sam_pkg::ST_EXEC;
            end
            sam_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = sam_pkg::ST_IDLE;
            end
            default: begin
                n_state = sam_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != sam_pkg::ST_IDLE);

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.clear, o_cmd.scan, o_cmd.exec}))
        else $error("controller issued more than one command");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !(o_cmd.clear || o_cmd.scan || o_cmd.exec))
        else $error("work command while not busy");

    a_last_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sam_pkg::ST_LAST) |-> ($past(r_state) == sam_pkg::ST_SCAN))
        else $error("final compare not preceded by scan");

endmodule

[src/sam_dp.sv]
// Datapath for the sparse array map: tag/value memories, scan compare, update.
module sam_dp #(
    parameter int CAPACITY = sam_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sam_pkg::t_ctrl_cmd                  i_ctrl,
    output sam_pkg::t_ctrl_sts                  o_sts,
    input  logic                                i_cfg_we,
    input  logic signed [sam_pkg::DATA_W-1:0]   i_cfg_wdata,
    input  logic [sam_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [sam_pkg::DATA_W-1:0]   i_key,
    input  logic signed [sam_pkg::DATA_W-1:0]   i_operand,
    input  logic [sam_pkg::SHIFT_W-1:0]         i_shift_amount,
    output logic                                o_done,
    output logic signed [sam_pkg::DATA_W-1:0]   o_result_value,
    output logic [sam_pkg::LIVE_W-1:0]          o_live_count,
    output logic                                o_full_error
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DW    = sam_pkg::DATA_W;

    // tag = {valid, key}
    logic [DW:0]   r_tag_mem [CAPACITY];
    logic [DW-1:0] r_val_mem [CAPACITY];

    logic [DW-1:0]              r_default;
    logic [sam_pkg::CMD_W-1:0]  r_cmd;
    logic [DW-1:0]              r_key;
    logic [DW-1:0]              r_opnd;
    logic [sam_pkg::SHIFT_W-1:0] r_sh;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_cmp_vld;
    logic [DW:0]      r_tag_q;
    logic [DW-1:0]    r_val_q;

    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [DW-1:0]    r_old;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic          r_out_vld;
    logic [DW-1:0] r_out_res;
    logic          r_out_err;

    // update logic
    logic [DW-1:0]    old_val;
    logic [DW-1:0]    res_val;
    logic [DW-1:0]    new_val;
    logic             do_store;
    logic             err;
    logic             tag_we;
    logic             val_we;
    logic [IDX_W-1:0] w_addr;
    logic [DW:0]      tag_wd;
    logic             idx_last;

    assign idx_last     = (r_idx == IDX_W'(CAPACITY - 1));
    assign o_sts.idx_last = idx_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= '0;
        end else if (i_cfg_we) begin
            r_default <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_cmd;
            r_key  <= i_key;
            r_opnd <= i_operand;
            r_sh   <= i_shift_amount;
        end
    end

    // scan index, shared by clear pass and lookup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_ctrl.load) begin
            r_idx <= '0;
        end else if (i_ctrl.clear || i_ctrl.scan) begin
            r_idx <= idx_last ? '0 : r_idx + 1'b1;
        end
    end

    // registered memory reads
    always_ff @(posedge i_clk) begin
        if (i_ctrl.scan) begin
            r_tag_q  <= r_tag_mem[r_idx];
            r_val_q  <= r_val_mem[r_idx];
            r_rd_idx <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_ctrl.scan;
        end
    end

    // first match and lowest free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_ctrl.load) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_cmp_vld) begin
            if (r_tag_q[DW] && (r_tag_q[DW-1:0] == r_key) && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (!r_tag_q[DW] && !r_free) begin
                r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_vld) begin
            if (r_tag_q[DW] && (r_tag_q[DW-1:0] == r_key) && !r_hit) begin
                r_hit_idx <= r_rd_idx;
                r_old     <= r_val_q;
            end
            if (!r_tag_q[DW] && !r_free) begin
                r_free_idx <= r_rd_idx;
            end
        end
    end

    always_comb begin
        old_val  = r_hit ? r_old : r_default;
        res_val  = old_val;
        new_val  = old_val;
        do_store = 1'b1;
        case (sam_pkg::t_op'(r_cmd))
            sam_pkg::OP_ASSIGN: begin
                res_val = r_opnd;
                new_val = r_opnd;
            end
            sam_pkg::OP_ADD: begin
                res_val = old_val + r_opnd;
                new_val = res_val;
            end
            sam_pkg::OP_PREINC: begin
                res_val = old_val + 1'b1;
                new_val = res_val;
            end
            sam_pkg::OP_POSTINC: begin
                new_val = old_val + 1'b1;
            end
            sam_pkg::OP_SHL: begin
                res_val = old_val << r_sh;
                new_val = res_val;
            end
            default: begin
                do_store = 1'b0;
            end
        endcase

        err     = 1'b0;
        tag_we  = 1'b0;
        val_we  = 1'b0;
        w_addr  = r_hit_idx;
        tag_wd  = {1'b1, r_key};
        n_count = r_count;
        if (i_ctrl.clear) begin
            tag_we = 1'b1;
            w_addr = r_idx;
            tag_wd = '0;
        end else if (i_ctrl.exec && do_store) begin
            if (new_val == r_default) begin
                if (r_hit) begin
                    tag_we  = 1'b1;
                    tag_wd  = '0;
                    n_count = r_count - 1'b1;
                end
            end else if (r_hit) begin
                val_we = 1'b1;
            end else if (r_free) begin
                tag_we  = 1'b1;
                val_we  = 1'b1;
                w_addr  = r_free_idx;
                n_count = r_count + 1'b1;
            end else begin
                err = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[w_addr] <= tag_wd;
        end
        if (val_we) begin
            r_val_mem[w_addr] <= new_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_out_vld <= i_ctrl.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            r_out_res <= res_val;
            r_out_err <= err;
        end
    end

    assign o_done         = r_out_vld;
    assign o_result_value = r_out_res;
    assign o_full_error   = r_out_err;
    assign o_live_count   = sam_pkg::LIVE_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("live count above capacity");

    a_err_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_err) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("full error with free slots left");

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $past(i_ctrl.exec))
        else $error("result beat without update cycle");

endmodule

[src/sparse_array_map_top.sv]
// Top level of the sparse array map: controller plus datapath.
//
//  channel   direction  handshake              payload
//  request   in         start & !busy          i_cmd, i_key, i_operand, i_shift_amount
//  result    out        o_done (one cycle)     o_result_value, o_live_count, o_full_error
//  config    in         i_cfg_we               i_cfg_wdata (default value)
//
// Each request beat holds busy high through a scan of all slots via
// the tag/value memory read port (one entry a cycle), a final compare, then the
// read-modify-write. The result beat shows in the cycle after that, while
// busy is already low, so a new request may be taken in the same cycle.
// After reset a clearing pass wipes the valid bit of every slot, one per cycle,
// and busy stays high until it ends. Config writes are taken at any time.
// The receiver cannot stall; o_done is a one-cycle strobe.
module sparse_array_map_top #(
    parameter int CAPACITY = sam_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sam_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [sam_pkg::DATA_W-1:0]   i_key,
    input  logic signed [sam_pkg::DATA_W-1:0]   i_operand,
    input  logic [sam_pkg::SHIFT_W-1:0]         i_shift_amount,
    input  logic                                i_cfg_we,
    input  logic signed [sam_pkg::DATA_W-1:0]   i_cfg_wdata,
    output logic                                o_done,
    output logic signed [sam_pkg::DATA_W-1:0]   o_result_value,
    output logic [sam_pkg::LIVE_W-1:0]          o_live_count,
    output logic                                o_full_error
);

    sam_pkg::t_ctrl_cmd ctrl_cmd;
    sam_pkg::t_ctrl_sts ctrl_sts;

    sam_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (ctrl_sts),
        .o_cmd   (ctrl_cmd)
    );

    // datapath: memories, scan compare, update and result register
    sam_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl_cmd),
        .o_sts          (ctrl_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (i_cmd),
        .i_key          (i_key),
        .i_operand      (i_operand),
        .i_shift_amount (i_shift_amount),
        .o_done         (o_done),
        .o_result_value (o_result_value),
        .o_live_count   (o_live_count),
        .o_full_error   (o_full_error)
    );

endmodule

[verif/sparse_array_map_top_tb.sv]
// Testbench for sparse_array_map_top: random and directed requests checked against a predictor.
`timescale 1ns / 100ps

module sparse_array_map_top_tb;

    localparam int CAPACITY      = sam_pkg::CAPACITY_DEF;
    localparam int DATA_W        = sam_pkg::DATA_W;
    localparam int CMD_W         = sam_pkg::CMD_W;
    localparam int SHIFT_W       = sam_pkg::SHIFT_W;
    localparam int LIVE_W        = sam_pkg::LIVE_W;
    localparam int MAP_LAT       = CAPACITY + 3;   // scan, compare, rmw, result beat
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_SHOWN     = 40;
    localparam int POOL_DEPTH    = 128;
    localparam int SLOT_W        = $clog2(CAPACITY);
    localparam int POOL_W        = $clog2(POOL_DEPTH);

    // command codes the block treats as a plain read
    localparam logic [CMD_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [DATA_W-1:0]  key;
        logic [DATA_W-1:0]  operand;
        logic [SHIFT_W-1:0] shamt;
    } t_map_req;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [LIVE_W-1:0] live;
        logic              full;
    } t_map_rsp;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      start          = 1'b0;
    logic [CMD_W-1:0]          i_cmd          = '0;
    logic signed [DATA_W-1:0]  i_key          = '0;
    logic signed [DATA_W-1:0]  i_operand      = '0;
    logic [SHIFT_W-1:0]        i_shift_amount = '0;
    logic                      i_cfg_we       = 1'b0;
    logic signed [DATA_W-1:0]  i_cfg_wdata    = '0;
    logic                      busy;
    logic                      o_done;
    logic signed [DATA_W-1:0]  o_result_value;
    logic [LIVE_W-1:0]         o_live_count;
    logic                      o_full_error;

    sparse_array_map_top #(.CAPACITY(CAPACITY)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_key          (i_key),
        .i_operand      (i_operand),
        .i_shift_amount (i_shift_amount),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_result_value (o_result_value),
        .o_live_count   (o_live_count),
        .o_full_error   (o_full_error)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: shadow copy of the table and the default register
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] slot_key  [CAPACITY];
    logic [DATA_W-1:0] slot_val  [CAPACITY];
    bit                slot_used [CAPACITY];
    int                live_entries;
    logic [DATA_W-1:0] dflt_value;

    t_map_req          request_q[$];   // requests not yet handed to the driver
    t_map_rsp          response_q[$];  // responses owed by the block, oldest first
    t_map_req          req_hold;       // request currently offered on the ports
    bit                req_live;
    int                idle_pct;
    int                mismatch_count;
    int                cycle_count;
    logic [DATA_W-1:0] key_pool[POOL_DEPTH];

    initial begin
        for (int i = 0; i < CAPACITY; i++) slot_used[SLOT_W'(i)] = 1'b0;
        live_entries   = 0;
        dflt_value     = '0;
        req_live       = 1'b0;
        idle_pct       = 0;
        mismatch_count = 0;
        cycle_count    = 0;
    end

    // Applies one request to the shadow table and returns the response it owes.
    function automatic t_map_rsp apply_request(t_map_req r);
        int                hit;
        int                slot;
        bit                writes;
        logic [DATA_W-1:0] old_v;
        logic [DATA_W-1:0] new_v;
        t_map_rsp          rsp;
        hit = -1;
        for (int i = 0; i < CAPACITY; i++)
            if (hit < 0 && slot_used[SLOT_W'(i)] && slot_key[SLOT_W'(i)] == r.key) hit = i;
        old_v     = (hit >= 0) ? slot_val[SLOT_W'(hit)] : dflt_value;
        new_v     = old_v;
        writes    = 1'b1;
        rsp.value = old_v;
        rsp.full  = 1'b0;
        case (r.cmd)
            sam_pkg::OP_ASSIGN:  begin new_v = r.operand;         rsp.value = new_v; end
            sam_pkg::OP_ADD:     begin new_v = old_v + r.operand; rsp.value = new_v; end
            sam_pkg::OP_PREINC:  begin new_v = old_v + 1;         rsp.value = new_v; end
            sam_pkg::OP_POSTINC: begin new_v = old_v + 1;         rsp.value = old_v; end
            sam_pkg::OP_SHL:     begin new_v = old_v << r.shamt;  rsp.value = new_v; end
            default:             writes = 1'b0;   // read, reserved codes
        endcase
        if (writes) begin
            if (new_v == dflt_value) begin
                // back to default: free the slot, never allocate
                if (hit >= 0) begin
                    slot_used[SLOT_W'(hit)] = 1'b0;
                    live_entries--;
                end
            end else if (hit >= 0) begin
                slot_val[SLOT_W'(hit)] = new_v;
            end else begin
                slot = -1;
                for (int i = 0; i < CAPACITY; i++)
                    if (slot < 0 && !slot_used[SLOT_W'(i)]) slot = i;
                if (slot < 0) begin
                    rsp.full = 1'b1;
                end else begin
                    slot_used[SLOT_W'(slot)] = 1'b1;
                    slot_key[SLOT_W'(slot)]  = r.key;
                    slot_val[SLOT_W'(slot)]  = new_v;
                    live_entries++;
                end
            end
        end
        rsp.live = LIVE_W'(live_entries);
        return rsp;
    endfunction

    function automatic t_map_req make_req(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] key,
                                          logic [DATA_W-1:0] operand,
                                          logic [SHIFT_W-1:0] shamt);
        t_map_req r;
        r.cmd     = cmd;
        r.key     = key;
        r.operand = operand;
        r.shamt   = shamt;
        return r;
    endfunction

    // Fill mode leans on assigns to many keys so the table runs full.
    function automatic t_map_req random_req(int pool_n, bit fill_mode);
        t_map_req r;
        int       roll;
        roll = $urandom_range(0, 99);
        if (fill_mode) begin
            if      (roll < 55) r.cmd = sam_pkg::OP_ASSIGN;
            else if (roll < 70) r.cmd = sam_pkg::OP_POSTINC;
            else if (roll < 80) r.cmd = sam_pkg::OP_ADD;
            else if (roll < 90) r.cmd = sam_pkg::OP_READ;
            else                r.cmd = CMD_W'($urandom_range(0, 7));
        end else if (roll < 6) begin
            r.cmd = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
        end else begin
            r.cmd = CMD_W'($urandom_range(0, 5));
        end
        r.key = ($urandom_range(0, 99) < 90) ? key_pool[POOL_W'($urandom_range(0, pool_n - 1))]
                                              : DATA_W'($urandom);
        roll = $urandom_range(0, 99);
        if (fill_mode)      r.operand = (roll < 5) ? dflt_value : DATA_W'($urandom);
        else if (roll < 20) r.operand = dflt_value;          // frees on assign
        else if (roll < 35) r.operand = dflt_value - 1;      // lands next to default
        else if (roll < 50) r.operand = DATA_W'($urandom_range(0, 15));
        else                r.operand = DATA_W'($urandom);
        r.shamt = SHIFT_W'($urandom_range(0, 31));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers one request beat at a time, idles at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                response_q.push_back(apply_request(req_hold));
                req_live = 1'b0;
            end
            if (!req_live && request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                req_hold = request_q.pop_front();
                req_live = 1'b1;
            end
            start          <= req_live;
            i_cmd          <= req_hold.cmd;
            i_key          <= req_hold.key;
            i_operand      <= req_hold.operand;
            i_shift_amount <= req_hold.shamt;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done beat must match the oldest owed response
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_SHOWN)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_map_rsp exp_rsp;
        if (i_rst_n && o_done) begin
            if (response_q.size() == 0) begin
                report_mismatch("result beat with no response owed");
            end else begin
                exp_rsp = response_q.pop_front();
                if (o_result_value !== exp_rsp.value)
                    report_mismatch($sformatf("result_value %h, expected %h",
                                              o_result_value, exp_rsp.value));
                if (o_live_count !== exp_rsp.live)
                    report_mismatch($sformatf("live_count %0d, expected %0d",
                                              o_live_count, exp_rsp.live));
                if (o_full_error !== exp_rsp.full)
                    report_mismatch($sformatf("full_error %b, expected %b",
                                              o_full_error, exp_rsp.full));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: reset, directed beats, then random phases with
    // default_value changes in between while the block is idle
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (request_q.size() != 0 || req_live || response_q.size() != 0)
            @(posedge i_clk);
        repeat (MAP_LAT) @(posedge i_clk);
    endtask

    task automatic write_default(logic [DATA_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        dflt_value   = v;   // taken at this edge
    endtask

    task automatic run_phase(int n, int pool_n, bit fill_mode, int idle);
        for (int i = 0; i < POOL_DEPTH; i++) key_pool[POOL_W'(i)] = DATA_W'($urandom);
        idle_pct = idle;
        for (int i = 0; i < n; i++) request_q.push_back(random_req(pool_n, fill_mode));
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, wraparound, freeing, reserved codes
        request_q.push_back(make_req(sam_pkg::OP_READ,    32'h0000_0000, 32'h0000_0000, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_READ,    32'h8000_0000, 32'hFFFF_FFFF, 5'd31));
        request_q.push_back(make_req(sam_pkg::OP_ASSIGN,  32'h7FFF_FFFF, 32'h8000_0000, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_READ,    32'h7FFF_FFFF, 32'h0000_0000, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_ADD,     32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_PREINC,  32'h7FFF_FFFF, 32'h0000_0000, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_POSTINC, 32'h8000_0000, 32'h0000_0000, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_SHL,     32'h8000_0000, 32'h0000_0000, 5'd31));
        request_q.push_back(make_req(sam_pkg::OP_SHL,     32'h8000_0000, 32'h0000_0000, 5'd1));
        request_q.push_back(make_req(sam_pkg::OP_ASSIGN,  32'h0000_0005, 32'h0000_0000, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_ADD,     32'h0000_0005, 32'h0000_0000, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_ASSIGN,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_PREINC,  32'hFFFF_FFFF, 32'h0000_0000, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_POSTINC, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_ADD,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_SHL,     32'h1234_5678, 32'h0000_0000, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_ASSIGN,  32'h1234_5678, 32'h7FFF_FFFF, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_POSTINC, 32'h1234_5678, 32'h0000_0000, 5'd0));
        request_q.push_back(make_req(OP_RSVD6,            32'h1234_5678, 32'hFFFF_FFFF, 5'd31));
        request_q.push_back(make_req(OP_RSVD7,            32'h1234_5678, 32'hFFFF_FFFF, 5'd31));
        request_q.push_back(make_req(sam_pkg::OP_ASSIGN,  32'h7FFF_FFFF, 32'h0000_0000, 5'd0));
        request_q.push_back(make_req(sam_pkg::OP_READ,    32'h7FFF_FFFF, 32'h0000_0000, 5'd0));
        wait_drained();

        // random phases; fill phases drive the table into the full case
        run_phase(150, 6, 1'b0, 0);
        run_phase(200, 80, 1'b1, 82);
        write_default(32'h7FFF_FFFF);
        run_phase(150, 16, 1'b0, 10);
        write_default(32'h8000_0000);
        run_phase(200, 100, 1'b1, 0);
        write_default(DATA_W'($urandom));
        run_phase(150, 10, 1'b0, 82);
        write_default(32'hFFFF_FFFF);
        run_phase(150, 70, 1'b1, 10);
        write_default(32'h0000_0000);
        run_phase(100, 40, 1'b0, 0);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/sam_pkg.sv
src/sam_ctrl.sv
src/sam_dp.sv
src/sparse_array_map_top.sv
verif/sparse_array_map_top_tb.sv
